[sv/irr_pkg.sv]
package irr_pkg;

    // Field widths of the stream payloads.
    localparam int ADC_W       = 12;
    localparam int DIST_W      = 7;
    localparam int MAX_POINTS  = 2048;
    localparam int INDEX_W     = $clog2(MAX_POINTS);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Range curve taken from the sensor datasheet, breakpoints in descending reading order.
    localparam int N_KNEES = 10;
    localparam int N_SEGS  = N_KNEES - 1;
    localparam int SEG_W   = $clog2(N_KNEES);

    localparam int KNEE_X [N_KNEES] = '{2860, 2020, 1610, 1340, 1140, 910, 757, 640, 540, 508};
    localparam int KNEE_Y [N_KNEES] = '{10, 15, 20, 25, 30, 40, 50, 60, 70, 80};

    // Segment slope as a rounded-up fixed-point reciprocal: dy * 2^FRAC_BITS / dx.
    // With spans below 2^10 and FRAC_BITS = 20 the truncated product equals the exact quotient.
    localparam int FRAC_BITS = 20;
    localparam int RECIP_W   = 19;
    localparam int SPAN_W    = 10;
    localparam int Q_W       = 4;
    localparam int PROD_W    = SPAN_W + RECIP_W;

    localparam int RECIP [N_SEGS] = '{
        (((KNEE_Y[1] - KNEE_Y[0]) << FRAC_BITS) + (KNEE_X[0] - KNEE_X[1]) - 1)
            / (KNEE_X[0] - KNEE_X[1]),
        (((KNEE_Y[2] - KNEE_Y[1]) << FRAC_BITS) + (KNEE_X[1] - KNEE_X[2]) - 1)
            / (KNEE_X[1] - KNEE_X[2]),
        (((KNEE_Y[3] - KNEE_Y[2]) << FRAC_BITS) + (KNEE_X[2] - KNEE_X[3]) - 1)
            / (KNEE_X[2] - KNEE_X[3]),
        (((KNEE_Y[4] - KNEE_Y[3]) << FRAC_BITS) + (KNEE_X[3] - KNEE_X[4]) - 1)
            / (KNEE_X[3] - KNEE_X[4]),
        (((KNEE_Y[5] - KNEE_Y[4]) << FRAC_BITS) + (KNEE_X[4] - KNEE_X[5]) - 1)
            / (KNEE_X[4] - KNEE_X[5]),
        (((KNEE_Y[6] - KNEE_Y[5]) << FRAC_BITS) + (KNEE_X[5] - KNEE_X[6]) - 1)
            / (KNEE_X[5] - KNEE_X[6]),
        (((KNEE_Y[7] - KNEE_Y[6]) << FRAC_BITS) + (KNEE_X[6] - KNEE_X[7]) - 1)
            / (KNEE_X[6] - KNEE_X[7]),
        (((KNEE_Y[8] - KNEE_Y[7]) << FRAC_BITS) + (KNEE_X[7] - KNEE_X[8]) - 1)
            / (KNEE_X[7] - KNEE_X[8]),
        (((KNEE_Y[9] - KNEE_Y[8]) << FRAC_BITS) + (KNEE_X[8] - KNEE_X[9]) - 1)
            / (KNEE_X[8] - KNEE_X[9])
    };

    // Block averaging over a power-of-two group.
    localparam int AVG_GROUP = 8;
    localparam int GROUP_W   = $clog2(AVG_GROUP);
    localparam int SUM_W     = DIST_W + GROUP_W;

    // Distance limits of the curve.
    localparam int DIST_MIN = 10;
    localparam int DIST_MAX = 80;

endpackage

[sv/ir_ranger_adc_to_distance_averager_core.sv]
// Infrared ranger: converts 12-bit sensor samples to distances in centimeters.
//
// Input stream (s_axis): tdata carries the ADC sample, tuser marks the first
// sample of a scan, which restarts the averaging group and the output index.
// Output stream (m_axis): tdata carries the distance and its index in the scan.
// Configuration: i_cfg_we writes i_cfg_wdata into the fine-mode bit; write it
// only while no transaction is in flight.
//
// In fine mode every input transaction yields one output transaction. In coarse
// mode eight samples are summed and their truncated average is emitted on the
// eighth; the other samples produce no output.
//
// Throughput is one transaction per cycle while the receiver takes results. An accepted
// sample is held in the input register and its result is then loaded into the output
// register, which drives o_m_axis_tvalid until the result leaves. The segment compare,
// one constant-reciprocal multiply and the accumulator add form the single path
// between the two registers.
// When the receiver stalls, the output register holds its result and the input
// register holds the next sample; s_axis tready drops only when both are full.
// Reset (synchronous, active low) empties both registers, clears the counters
// and the running sum, and selects coarse mode.
module ir_ranger_adc_to_distance_averager_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [11:0] adc_reading, [15:12] zero
    input  logic [irr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] start_of_scan
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [6:0] distance_cm, [17:7] point_index, [23:18] zero
    output logic [irr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    localparam int PAD_W = irr_pkg::OUT_TDATA_W - irr_pkg::DIST_W - irr_pkg::INDEX_W;

    logic                          r_fine_mode;

    // Input register.
    logic                          r_in_valid;
    logic [irr_pkg::ADC_W-1:0]     r_in_reading;
    logic                          r_in_start;

    // Running state of the scan.
    logic [irr_pkg::GROUP_W-1:0]   r_sample_count, n_sample_count;
    logic [irr_pkg::SUM_W-1:0]     r_distance_sum, n_distance_sum;
    logic [irr_pkg::INDEX_W-1:0]   r_output_count, n_output_count;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    logic [irr_pkg::DIST_W-1:0]    r_out_dist, n_out_dist;
    logic [irr_pkg::INDEX_W-1:0]   r_out_index, n_out_index;

    logic                          out_free;
    logic                          advance;
    logic                          in_accept;

    // Conversion path.
    logic [irr_pkg::SEG_W-1:0]     seg;
    logic                          in_seg;
    logic [irr_pkg::ADC_W-1:0]     span_full;
    logic [irr_pkg::SPAN_W-1:0]    span;
    logic [irr_pkg::RECIP_W-1:0]   recip;
    logic [irr_pkg::PROD_W-1:0]    prod;
    logic [irr_pkg::Q_W-1:0]       quot;
    logic [irr_pkg::DIST_W-1:0]    dist_cm;

    // Averaging path.
    logic [irr_pkg::GROUP_W-1:0]   count_base;
    logic [irr_pkg::SUM_W-1:0]     sum_base;
    logic [irr_pkg::SUM_W-1:0]     sum_next;
    logic [irr_pkg::INDEX_W-1:0]   index_base;

    // The output register can take a new result when it is empty or being drained.
    // A sample that ends without a result also needs it free, which keeps order simple.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_fine_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_reading <= i_s_axis_tdata[irr_pkg::ADC_W-1:0];
            r_in_start   <= i_s_axis_tuser;
        end
    end

    // Find the curve segment holding the sample; the segments do not overlap,
    // so at most one compare pair matches.
    always_comb begin
        seg    = '0;
        in_seg = 1'b0;
        for (int s = 0; s < irr_pkg::N_SEGS; s++) begin
            if ((r_in_reading <= irr_pkg::ADC_W'(irr_pkg::KNEE_X[s])) &&
                (r_in_reading >  irr_pkg::ADC_W'(irr_pkg::KNEE_X[s + 1]))) begin
                seg    = irr_pkg::SEG_W'(s);
                in_seg = 1'b1;
            end
        end
    end

    // Interpolate: distance below the upper knee times the segment slope.
    always_comb begin
        span_full = irr_pkg::ADC_W'(irr_pkg::KNEE_X[seg]) - r_in_reading;
        span      = span_full[irr_pkg::SPAN_W-1:0];
        recip     = irr_pkg::RECIP_W'(irr_pkg::RECIP[seg]);
        prod      = irr_pkg::PROD_W'(span) * irr_pkg::PROD_W'(recip);
        quot      = prod[irr_pkg::FRAC_BITS +: irr_pkg::Q_W];

        if (r_in_reading > irr_pkg::ADC_W'(irr_pkg::KNEE_X[0])) begin
            dist_cm = irr_pkg::DIST_W'(irr_pkg::KNEE_Y[0]);
        end else if (in_seg) begin
            dist_cm = irr_pkg::DIST_W'(irr_pkg::KNEE_Y[seg]) + irr_pkg::DIST_W'(quot);
        end else begin
            dist_cm = irr_pkg::DIST_W'(irr_pkg::KNEE_Y[irr_pkg::N_KNEES - 1]);
        end
    end

    // Scan state and result. A start-of-scan sample sees cleared counters and sum.
    always_comb begin
        count_base = r_in_start ? '0 : r_sample_count;
        sum_base   = r_in_start ? '0 : r_distance_sum;
        index_base = r_in_start ? '0 : r_output_count;
        sum_next   = sum_base + irr_pkg::SUM_W'(dist_cm);

        n_sample_count = r_sample_count;
        n_distance_sum = r_distance_sum;
        n_output_count = r_output_count;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_dist     = r_out_dist;
        n_out_index    = r_out_index;

        if (advance) begin
            n_sample_count = count_base;
            n_distance_sum = sum_base;
            n_output_count = index_base;
            if (r_fine_mode) begin
                // In fine mode the averaging group is only cleared by a start-of-scan sample.
                n_out_valid    = 1'b1;
                n_out_dist     = dist_cm;
                n_out_index    = index_base;
                n_output_count = index_base + 1'b1;
            end else if (count_base == irr_pkg::GROUP_W'(irr_pkg::AVG_GROUP - 1)) begin
                n_out_valid    = 1'b1;
                n_out_dist     = sum_next[irr_pkg::SUM_W-1:irr_pkg::GROUP_W];
                n_out_index    = index_base;
                n_output_count = index_base + 1'b1;
                n_sample_count = '0;
                n_distance_sum = '0;
            end else begin
                n_sample_count = count_base + 1'b1;
                n_distance_sum = sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_distance_sum <= '0;
            r_output_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_sample_count <= n_sample_count;
            r_distance_sum <= n_distance_sum;
            r_output_count <= n_output_count;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dist  <= n_out_dist;
        r_out_index <= n_out_index;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_index, r_out_dist};

endmodule

[sv/irr_checker.sv]
module irr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [irr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic [irr_pkg::DIST_W-1:0] out_dist;

    assign out_dist = o_m_axis_tdata[irr_pkg::DIST_W-1:0];

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output payload changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // Every distance lies on the sensor curve.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_dist >= irr_pkg::DIST_W'(irr_pkg::DIST_MIN)) &&
                            (out_dist <= irr_pkg::DIST_W'(irr_pkg::DIST_MAX)))
        else $error("distance outside the curve range");

    // Input back-pressure appears only while a result waits on a stalled receiver.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind ir_ranger_adc_to_distance_averager_core irr_checker u_irr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
